// ----- hw/rtl/vlsbi_pkg.sv -----
// Shared types and codes for the vector load/store burst issuer.
// Used by vlsbi_insn_queue and vector_load_store_burst_issuer_core; no dependencies.
package vlsbi_pkg;

    typedef enum logic [1:0] {
        CMD_ENQUEUE  = 2'd0,
        CMD_TICK     = 2'd1,
        CMD_GRANT    = 2'd2,
        CMD_RESPONSE = 2'd3
    } cmd_t;

    typedef enum logic [1:0] {
        REPLY_OK      = 2'd0,
        REPLY_INVALID = 2'd1,
        REPLY_DENIED  = 2'd2,
        REPLY_PENDING = 2'd3
    } reply_t;

    localparam logic [2:0] WIDTH_CODE_MIN_WIDE = 3'd5;
    localparam logic [2:0] WIDTH_CODE_BIAS     = 3'd4;

    typedef struct packed {
        logic [63:0] base_addr;
        logic [2:0]  width_code;
        logic [12:0] vector_length;
        logic [12:0] start_element;
        logic        is_store;
        logic [15:0] data_offset;
    } insn_t;

    typedef struct packed {
        logic push;
        logic pop;
    } queue_ctrl_t;

    typedef struct packed {
        logic empty;
        logic single;
        logic full;
    } queue_status_t;

endpackage

// ----- hw/rtl/vlsbi_insn_queue.sv -----
// Circular instruction queue; the head entry is the instruction being worked on.
// Depends on vlsbi_pkg.
module vlsbi_insn_queue
    import vlsbi_pkg::*;
#(
    parameter int QUEUE_DEPTH = 4
) (
    input  logic          aclk,
    input  logic          aresetn,
    input  queue_ctrl_t   ctrl,
    input  insn_t         push_insn,
    output insn_t         head_insn,
    output queue_status_t status
);

    localparam int HW = (QUEUE_DEPTH > 1) ? $clog2(QUEUE_DEPTH) : 1;
    localparam int CW = $clog2(QUEUE_DEPTH + 1);

    insn_t entry_reg [QUEUE_DEPTH];

    logic [HW-1:0] head_reg, head_next;
    logic [CW-1:0] count_reg, count_next;
    logic [CW:0]   tail_sum;
    logic [HW-1:0] tail_idx;

    always_comb begin
        tail_sum = {1'b0, {(CW-HW){1'b0}}, head_reg} + {1'b0, count_reg};
        if (tail_sum >= (CW+1)'(QUEUE_DEPTH)) begin
            tail_sum = tail_sum - (CW+1)'(QUEUE_DEPTH);
        end
        tail_idx = tail_sum[HW-1:0];
    end

    always_comb begin
        head_next  = head_reg;
        count_next = count_reg;
        if (ctrl.pop) begin
            head_next  = (head_reg == HW'(QUEUE_DEPTH - 1)) ? '0 : head_reg + 1'b1;
            count_next = count_next - 1'b1;
        end
        if (ctrl.push) begin
            count_next = count_next + 1'b1;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            head_reg  <= '0;
            count_reg <= '0;
        end else begin
            head_reg  <= head_next;
            count_reg <= count_next;
        end
    end

    always_ff @(posedge aclk) begin
        if (ctrl.push) begin
            entry_reg[tail_idx] <= push_insn;
        end
    end

    assign head_insn     = entry_reg[head_reg];
    assign status.empty  = (count_reg == '0);
    assign status.single = (count_reg == CW'(1));
    assign status.full   = (count_reg >= CW'(QUEUE_DEPTH));

endmodule

// ----- hw/rtl/vector_load_store_burst_issuer_core.sv -----
// Vector load/store burst issuer: queues vector memory instructions and splits
// each into bursts of at most LANES*8 bytes. Depends on vlsbi_pkg, vlsbi_insn_queue.
//
// One transaction in gives exactly one result transaction out. Each input
// transaction is captured in an input register, evaluated against the unit state
// and written to the result register, so a new transaction is accepted every
// cycle as long as results are taken. The result is presented from the result
// register once the transaction has passed through the input register; the rate
// is set by the state update between input and result register.
// s_tuser carries the command (enqueue, tick, grant, response). A tick
// issues at most one burst, when bytes remain, fewer than MAX_OUTSTANDING bursts
// are outstanding and the unit is not stalled by a denied reply.
module vector_load_store_burst_issuer_core
    import vlsbi_pkg::*;
#(
    parameter int LANES           = 4,
    parameter int MAX_OUTSTANDING = 4,
    parameter int QUEUE_DEPTH     = 4
) (
    input  logic         aclk,
    input  logic         aresetn,
    input  logic         s_tvalid,
    output logic         s_tready,
    // base_addr[63:0], width_code[66:64], vector_length[79:67], start_element[92:80],
    // is_store[93], data_offset[109:94], mem_reply[111:110]
    input  logic [111:0] s_tdata,
    // cmd[1:0]
    input  logic [1:0]   s_tuser,
    output logic         m_tvalid,
    input  logic         m_tready,
    // burst_valid[0], burst_addr[64:1], burst_bytes[70:65], burst_is_write[71],
    // burst_data_offset[87:72], insn_done[88], enqueue_rejected[89], busy_res[90],
    // zero fill[95:91]
    output logic [95:0]  m_tdata
);

    localparam int CAP = LANES * 8;
    localparam int SZW = $clog2(CAP + 1);
    localparam int OW  = $clog2(MAX_OUTSTANDING + 1);

    // input register
    logic         in_valid_reg, in_valid_next;
    logic [111:0] in_data_reg;
    cmd_t         in_cmd_reg;
    logic         proc;

    // unit state
    logic          active_reg, active_next;
    logic [63:0]   cur_addr_reg, cur_addr_next;
    logic [15:0]   rem_reg, rem_next;
    logic [15:0]   cur_off_reg, cur_off_next;
    logic          cur_write_reg, cur_write_next;
    logic [OW-1:0] out_cnt_reg, out_cnt_next;
    logic          stalled_reg, stalled_next;

    // result register
    logic          m_valid_reg, m_valid_next;
    logic [95:0]   m_data_reg, m_data_next;

    queue_ctrl_t   q_ctrl;
    queue_status_t q_status;
    insn_t         push_insn;
    insn_t         head_insn;

    logic          r_bvalid, r_write, r_done, r_rej, r_busy, q_empty_after;
    logic [63:0]   r_addr;
    logic [5:0]    r_bytes;
    logic [15:0]   r_off;
    reply_t        reply;

    assign proc          = in_valid_reg && (!m_valid_reg || m_tready);
    assign s_tready      = !in_valid_reg || proc;
    assign in_valid_next = s_tready ? s_tvalid : in_valid_reg;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            in_valid_reg <= 1'b0;
        end else begin
            in_valid_reg <= in_valid_next;
        end
    end

    always_ff @(posedge aclk) begin
        if (s_tvalid && s_tready) begin
            in_data_reg <= s_tdata;
            in_cmd_reg  <= cmd_t'(s_tuser);
        end
    end

    assign push_insn.base_addr     = in_data_reg[63:0];
    assign push_insn.width_code    = in_data_reg[66:64];
    assign push_insn.vector_length = in_data_reg[79:67];
    assign push_insn.start_element = in_data_reg[92:80];
    assign push_insn.is_store      = in_data_reg[93];
    assign push_insn.data_offset   = in_data_reg[109:94];
    assign reply                   = reply_t'(in_data_reg[111:110]);

    vlsbi_insn_queue #(
        .QUEUE_DEPTH (QUEUE_DEPTH)
    ) u_queue (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .ctrl      (q_ctrl),
        .push_insn (push_insn),
        .head_insn (head_insn),
        .status    (q_status)
    );

    always_comb begin
        logic [1:0]     esz_shift;
        logic [12:0]    elem_cnt;
        logic [SZW-1:0] size;

        active_next    = active_reg;
        cur_addr_next  = cur_addr_reg;
        rem_next       = rem_reg;
        cur_off_next   = cur_off_reg;
        cur_write_next = cur_write_reg;
        out_cnt_next   = out_cnt_reg;
        stalled_next   = stalled_reg;
        q_ctrl         = '0;
        r_bvalid       = 1'b0;
        r_addr         = '0;
        r_bytes        = '0;
        r_write        = 1'b0;
        r_off          = '0;
        r_done         = 1'b0;
        r_rej          = 1'b0;
        esz_shift      = '0;
        elem_cnt       = '0;
        size           = '0;

        if (proc) begin
            unique case (in_cmd_reg)
                CMD_ENQUEUE: begin
                    if (q_status.full) begin
                        r_rej = 1'b1;
                    end else begin
                        q_ctrl.push = 1'b1;
                    end
                end
                CMD_TICK: begin
                    if (!active_reg && !q_status.empty) begin
                        if (head_insn.width_code >= WIDTH_CODE_MIN_WIDE) begin
                            esz_shift = 2'(head_insn.width_code - WIDTH_CODE_BIAS);
                        end
                        if (head_insn.start_element < head_insn.vector_length) begin
                            elem_cnt = head_insn.vector_length - head_insn.start_element;
                        end
                        rem_next       = {3'b000, elem_cnt} << esz_shift;
                        cur_addr_next  = head_insn.base_addr;
                        cur_off_next   = head_insn.data_offset;
                        cur_write_next = head_insn.is_store;
                        active_next    = 1'b1;
                        if (rem_next == '0 && out_cnt_reg == '0) begin
                            active_next = 1'b0;
                            q_ctrl.pop  = 1'b1;
                            r_done      = 1'b1;
                        end
                    end
                    if (active_next && rem_next != '0
                            && out_cnt_reg < OW'(MAX_OUTSTANDING) && !stalled_reg) begin
                        size     = (rem_next < 16'(CAP)) ? SZW'(rem_next) : SZW'(CAP);
                        r_bvalid = 1'b1;
                        r_addr   = cur_addr_next;
                        r_bytes  = 6'(size);
                        r_write  = cur_write_next;
                        r_off    = cur_off_next;
                        case (reply)
                            REPLY_DENIED: begin
                                stalled_next = 1'b1;
                                out_cnt_next = out_cnt_reg + 1'b1;
                            end
                            REPLY_PENDING: begin
                                out_cnt_next = out_cnt_reg + 1'b1;
                            end
                            default: begin
                                out_cnt_next = out_cnt_reg;
                            end
                        endcase
                        cur_addr_next = cur_addr_next + 64'(size);
                        rem_next      = rem_next - 16'(size);
                        cur_off_next  = cur_off_next + 16'(size);
                        if (rem_next == '0 && out_cnt_next == '0) begin
                            active_next = 1'b0;
                            q_ctrl.pop  = 1'b1;
                            r_done      = 1'b1;
                        end
                    end
                end
                CMD_GRANT: begin
                    stalled_next = 1'b0;
                end
                CMD_RESPONSE: begin
                    if (out_cnt_reg != '0) begin
                        out_cnt_next = out_cnt_reg - 1'b1;
                        if (active_reg && rem_reg == '0 && out_cnt_next == '0) begin
                            active_next = 1'b0;
                            q_ctrl.pop  = 1'b1;
                            r_done      = 1'b1;
                        end
                    end
                end
            endcase
        end

        if (q_ctrl.push) begin
            q_empty_after = 1'b0;
        end else if (q_ctrl.pop) begin
            q_empty_after = q_status.single;
        end else begin
            q_empty_after = q_status.empty;
        end
        r_busy = active_next || !q_empty_after;
    end

    assign m_data_next  = {5'b00000, r_busy, r_rej, r_done, r_off, r_write, r_bytes,
                           r_addr, r_bvalid};
    assign m_valid_next = proc ? 1'b1 : (m_valid_reg && !m_tready);

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            active_reg    <= 1'b0;
            cur_addr_reg  <= '0;
            rem_reg       <= '0;
            cur_off_reg   <= '0;
            cur_write_reg <= 1'b0;
            out_cnt_reg   <= '0;
            stalled_reg   <= 1'b0;
            m_valid_reg   <= 1'b0;
        end else begin
            active_reg    <= active_next;
            cur_addr_reg  <= cur_addr_next;
            rem_reg       <= rem_next;
            cur_off_reg   <= cur_off_next;
            cur_write_reg <= cur_write_next;
            out_cnt_reg   <= out_cnt_next;
            stalled_reg   <= stalled_next;
            m_valid_reg   <= m_valid_next;
        end
    end

    always_ff @(posedge aclk) begin
        if (proc) begin
            m_data_reg <= m_data_next;
        end
    end

    assign m_tvalid = m_valid_reg;
    assign m_tdata  = m_data_reg;

    a_out_cnt_bound: assert property (@(posedge aclk) disable iff (!aresetn)
        out_cnt_reg <= OW'(MAX_OUTSTANDING))
        else $error("outstanding burst count above limit");

    a_idle_no_outstanding: assert property (@(posedge aclk) disable iff (!aresetn)
        !active_reg |-> out_cnt_reg == '0)
        else $error("bursts outstanding with no active instruction");

    a_input_held: assert property (@(posedge aclk) disable iff (!aresetn)
        in_valid_reg && !proc |=> in_valid_reg && $stable(in_data_reg))
        else $error("stalled input transaction lost");

endmodule

// ----- bench/tb_top.sv -----
// Testbench for vector_load_store_burst_issuer_core: drives command transactions,
// predicts every result transaction in a scoreboard class and checks field by field.
// Depends on vlsbi_pkg and the core RTL.
module tb_top;
    timeunit 1ns;
    timeprecision 1ps;
    import vlsbi_pkg::*;

    localparam int LANES       = 4;
    localparam int MAX_OUT     = 4;
    localparam int QDEPTH      = 4;
    localparam int STUCK_LIMIT = 2000;

    typedef struct packed {
        cmd_t        cmd;
        logic [63:0] base;
        logic [2:0]  wcode;
        logic [12:0] vl;
        logic [12:0] vs;
        logic        st;
        logic [15:0] off;
        reply_t      reply;
    } op_t;

    typedef struct packed {
        logic        valid;
        logic [63:0] addr;
        logic [5:0]  bytes;
        logic        write;
        logic [15:0] off;
        logic        done;
        logic        rejected;
        logic        busy;
    } burst_result_t;

    class burst_scoreboard;
        op_t             insn_q[QDEPTH];
        int unsigned     head;
        int unsigned     count;
        bit              active;
        logic [63:0]     cur_addr;
        logic [15:0]     remaining;
        logic [15:0]     cur_off;
        bit              cur_write;
        int unsigned     outstanding;
        bit              stalled;
        burst_result_t   expected_bursts[$];
        int              errors;

        function new();
            head        = 0;
            count       = 0;
            active      = 0;
            cur_addr    = '0;
            remaining   = '0;
            cur_off     = '0;
            cur_write   = 0;
            outstanding = 0;
            stalled     = 0;
            errors      = 0;
        endfunction

        function bit retire_if_empty();
            if (active && remaining == 0 && outstanding == 0) begin
                head = (head + 1) % QDEPTH;
                if (count > 0) count--;
                active = 0;
                return 1;
            end
            return 0;
        endfunction

        function void note_input(op_t op);
            burst_result_t r;
            op_t           h;
            int unsigned   esz;
            int unsigned   total;
            int unsigned   sz;
            r = '0;
            case (op.cmd)
                CMD_ENQUEUE: begin
                    if (count >= QDEPTH) begin
                        r.rejected = 1'b1;
                    end else begin
                        insn_q[(head + count) % QDEPTH] = op;
                        count++;
                    end
                end
                CMD_TICK: begin
                    if (!active && count > 0) begin
                        h = insn_q[head];
                        esz = (h.wcode >= WIDTH_CODE_MIN_WIDE) ?
                              (1 << (h.wcode - WIDTH_CODE_BIAS)) : 1;
                        total = (h.vs >= h.vl) ? 0 : (int'(h.vl) - int'(h.vs)) * esz;
                        remaining = total[15:0];
                        cur_addr  = h.base;
                        cur_off   = h.off;
                        cur_write = h.st;
                        active    = 1;
                        if (remaining == 0 && retire_if_empty()) r.done = 1'b1;
                    end
                    if (active && remaining > 0 && outstanding < MAX_OUT && !stalled) begin
                        sz = (remaining < LANES * 8) ? remaining : LANES * 8;
                        r.valid = 1'b1;
                        r.addr  = cur_addr;
                        r.bytes = sz[5:0];
                        r.write = cur_write;
                        r.off   = cur_off;
                        if (op.reply == REPLY_DENIED) begin
                            stalled = 1;
                            outstanding++;
                        end else if (op.reply == REPLY_PENDING) begin
                            outstanding++;
                        end
                        cur_addr  = cur_addr + sz;
                        remaining = remaining - sz[15:0];
                        cur_off   = cur_off + sz[15:0];
                        if (retire_if_empty()) r.done = 1'b1;
                    end
                end
                CMD_GRANT: begin
                    stalled = 0;
                end
                default: begin
                    if (outstanding > 0) begin
                        outstanding--;
                        if (retire_if_empty()) r.done = 1'b1;
                    end
                end
            endcase
            r.busy = active || count > 0;
            expected_bursts.push_back(r);
        endfunction

        function void check_field(string name, logic [63:0] exp, logic [63:0] act);
            if (exp !== act) begin
                $error("%s: expected 0x%0h, got 0x%0h", name, exp, act);
                errors++;
            end
        endfunction

        function void check_result(logic [95:0] d);
            burst_result_t e;
            if (expected_bursts.size() == 0) begin
                $error("result transaction with nothing expected: 0x%0h", d);
                errors++;
                return;
            end
            e = expected_bursts.pop_front();
            check_field("burst_valid", e.valid, d[0]);
            check_field("burst_addr", e.addr, d[64:1]);
            check_field("burst_bytes", e.bytes, d[70:65]);
            check_field("burst_is_write", e.write, d[71]);
            check_field("burst_data_offset", e.off, d[87:72]);
            check_field("insn_done", e.done, d[88]);
            check_field("enqueue_rejected", e.rejected, d[89]);
            check_field("busy_res", e.busy, d[90]);
        endfunction

        function int pending();
            return expected_bursts.size();
        endfunction
    endclass

    logic         aclk     = 1'b0;
    logic         aresetn  = 1'b0;
    logic         s_tvalid = 1'b0;
    logic         s_tready;
    logic [111:0] s_tdata  = '0;
    logic [1:0]   s_tuser  = '0;
    logic         m_tvalid;
    logic         m_tready = 1'b0;
    logic [95:0]  m_tdata;

    int send_idle_pct  = 0;
    int recv_stall_pct = 0;
    int stuck_cycles   = 0;

    burst_scoreboard sb = new();

    vector_load_store_burst_issuer_core #(
        .LANES          (LANES),
        .MAX_OUTSTANDING(MAX_OUT),
        .QUEUE_DEPTH    (QDEPTH)
    ) dut (
        .aclk    (aclk),
        .aresetn (aresetn),
        .s_tvalid(s_tvalid),
        .s_tready(s_tready),
        .s_tdata (s_tdata),
        .s_tuser (s_tuser),
        .m_tvalid(m_tvalid),
        .m_tready(m_tready),
        .m_tdata (m_tdata)
    );

    always begin
        #10 aclk = 1'b1;
        #10 aclk = 1'b0;
    end

    always @(posedge aclk) begin
        m_tready <= ($urandom_range(99) >= recv_stall_pct);
    end

    always @(posedge aclk) begin
        if (aresetn && m_tvalid && m_tready) sb.check_result(m_tdata);
        if ((s_tvalid && s_tready) || (m_tvalid && m_tready) || !aresetn) begin
            stuck_cycles <= 0;
        end else begin
            stuck_cycles <= stuck_cycles + 1;
        end
        if (stuck_cycles >= STUCK_LIMIT) begin
            $display("*** FAILED ***");
            $finish;
        end
    end

    function automatic op_t make_op(cmd_t c, reply_t rp, logic [63:0] base = '0,
                                    logic [2:0] wcode = '0, logic [12:0] vl = '0,
                                    logic [12:0] vs = '0, logic st = 1'b0,
                                    logic [15:0] off = '0);
        op_t op;
        op.cmd   = c;
        op.reply = rp;
        op.base  = base;
        op.wcode = wcode;
        op.vl    = vl;
        op.vs    = vs;
        op.st    = st;
        op.off   = off;
        return op;
    endfunction

    function automatic op_t random_op();
        op_t         op;
        int unsigned pick;
        int unsigned shape;
        op.base  = {$urandom, $urandom};
        op.wcode = 3'($urandom_range(7));
        op.vl    = 13'($urandom_range(8191));
        op.vs    = 13'($urandom_range(8191));
        op.st    = 1'($urandom_range(1));
        op.off   = 16'($urandom_range(65535));
        op.reply = reply_t'($urandom_range(3));
        pick = $urandom_range(99);
        if (pick < 15) begin
            op.cmd = CMD_ENQUEUE;
            shape = $urandom_range(99);
            if (shape < 90) begin
                op.vl = 13'($urandom_range(40));
                op.vs = 13'($urandom_range(8));
            end else if (shape < 95) begin
                op.vs = (op.vl > 60) ? 13'(op.vl - $urandom_range(60)) : '0;
            end else begin
                op.vl = 13'($urandom_range(op.vs));
            end
        end else if (pick < 65) begin
            op.cmd = CMD_TICK;
            shape = $urandom_range(99);
            if (shape < 35)      op.reply = REPLY_OK;
            else if (shape < 50) op.reply = REPLY_INVALID;
            else if (shape < 65) op.reply = REPLY_DENIED;
            else                 op.reply = REPLY_PENDING;
        end else if (pick < 77) begin
            op.cmd = CMD_GRANT;
        end else begin
            op.cmd = CMD_RESPONSE;
        end
        return op;
    endfunction

    task automatic send_item(input op_t op);
        if ($urandom_range(99) < send_idle_pct) begin
            s_tvalid <= 1'b0;
            repeat ($urandom_range(3, 1)) @(posedge aclk);
        end
        s_tvalid <= 1'b1;
        s_tdata  <= {op.reply, op.off, op.st, op.vs, op.vl, op.wcode, op.base};
        s_tuser  <= op.cmd;
        do @(posedge aclk); while (!s_tready);
        sb.note_input(op);
    endtask

    task automatic hold_until_drained();
        s_tvalid <= 1'b0;
        while (sb.pending() > 0) @(posedge aclk);
    endtask

    initial begin
        int p;
        repeat (9) @(posedge aclk);
        aresetn <= 1'b1;
        @(posedge aclk);

        // idle unit: tick, grant and response with nothing to do
        send_item(make_op(CMD_TICK, REPLY_OK));
        send_item(make_op(CMD_GRANT, REPLY_DENIED));
        send_item(make_op(CMD_RESPONSE, REPLY_PENDING));
        // fill the queue; address and offset wrap, empty and reversed vectors
        send_item(make_op(CMD_ENQUEUE, REPLY_OK, 64'hFFFF_FFFF_FFFF_FFF0, 3'd7, 13'd8,
                          13'd0, 1'b1, 16'hFFF0));
        send_item(make_op(CMD_ENQUEUE, REPLY_OK, 64'h1000, 3'd0, 13'd0, 13'd0));
        send_item(make_op(CMD_ENQUEUE, REPLY_OK, 64'h2000, 3'd1, 13'd3, 13'd8191));
        send_item(make_op(CMD_ENQUEUE, REPLY_OK, 64'h3000, 3'd5, 13'd8191, 13'd8180,
                          1'b0, 16'h1234));
        send_item(make_op(CMD_ENQUEUE, REPLY_OK, 64'h4000, 3'd4, 13'd4, 13'd0));
        // burst of the wrapping store, then denied and stalled
        send_item(make_op(CMD_TICK, REPLY_OK));
        send_item(make_op(CMD_TICK, REPLY_DENIED));
        send_item(make_op(CMD_TICK, REPLY_OK));
        send_item(make_op(CMD_GRANT, REPLY_OK));
        send_item(make_op(CMD_RESPONSE, REPLY_OK));
        // empty and reversed vectors finish on the taking tick
        send_item(make_op(CMD_TICK, REPLY_OK));
        send_item(make_op(CMD_TICK, REPLY_OK));
        send_item(make_op(CMD_TICK, REPLY_PENDING));
        send_item(make_op(CMD_RESPONSE, REPLY_OK));
        // outstanding limit
        send_item(make_op(CMD_ENQUEUE, REPLY_OK, 64'h5000, 3'd6, 13'd40, 13'd0, 1'b1,
                          16'h0100));
        repeat (4) send_item(make_op(CMD_TICK, REPLY_PENDING));
        send_item(make_op(CMD_TICK, REPLY_OK));
        send_item(make_op(CMD_RESPONSE, REPLY_OK));
        send_item(make_op(CMD_TICK, REPLY_INVALID));
        repeat (3) send_item(make_op(CMD_RESPONSE, REPLY_OK));
        hold_until_drained();

        for (p = 0; p < 8; p++) begin
            case (p % 4)
                0: begin send_idle_pct = 0;  recv_stall_pct = 0;  end
                1: begin send_idle_pct = 51; recv_stall_pct = 0;  end
                2: begin send_idle_pct = 0;  recv_stall_pct = 51; end
                default: begin send_idle_pct = 21; recv_stall_pct = 21; end
            endcase
            repeat (95) send_item(random_op());
            hold_until_drained();
        end

        repeat (4) @(posedge aclk);
        if (sb.errors == 0 && sb.pending() == 0) begin
            $display("*** PASSED ***");
        end else begin
            $display("*** FAILED ***");
        end
        $finish;
    end
endmodule
